// File: sv/event_set_wait_engine_assert.svh
// assertion macros for the event set wait engine
`ifndef EVENT_SET_WAIT_ENGINE_ASSERT_SVH
`define EVENT_SET_WAIT_ENGINE_ASSERT_SVH

// antecedent holds, consequent follows in the next cycle
`define ESW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// antecedent and consequent hold in the same cycle
`define ESW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/esw_pkg.sv
// shared types, codes and helpers for the event set wait engine
package esw_pkg;

    // action codes
    localparam logic [2:0] ACT_ALLOC = 3'd0;
    localparam logic [2:0] ACT_FREE  = 3'd1;
    localparam logic [2:0] ACT_WAIT  = 3'd2;
    localparam logic [2:0] ACT_RAISE = 3'd3;
    localparam logic [2:0] ACT_MASK  = 3'd4;
    localparam logic [2:0] ACT_CLEAR = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd2;
    localparam logic [2:0] ST_NO_FREE   = 3'd3;
    localparam logic [2:0] ST_ENQUEUED  = 3'd4;

    localparam int          BITS_PER_SET = 32;
    localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;

    // one event set as held in memory
    typedef struct packed {
        logic [31:0] enable;
        logic [31:0] pending;
        logic [31:0] waiting;
    } t_entry;

    localparam int     ENTRY_W     = $bits(t_entry);
    localparam t_entry ENTRY_RESET = '{enable: ALL_ONES, pending: 32'h0, waiting: 32'h0};

    // latched item plus the checks made at accept time
    typedef struct packed {
        logic [2:0] action;
        logic [4:0] event_bit;
        logic       mask_value;
        logic [4:0] thread_id;
        logic [5:0] set_addr;
        logic       set_ok;
        logic       thread_ok;
        logic       in_use;
        logic       alloc_ok;
    } t_item;

    // state updates requested by the execute logic
    typedef struct packed {
        logic wr_en;
        logic use_set;
        logic use_clr;
    } t_ctl;

    // one result beat
    typedef struct packed {
        logic [2:0] status;
        logic [5:0] result_value;
        logic       wake_valid;
        logic [4:0] wake_thread;
        logic [4:0] wake_event;
    } t_result;

    // index of the lowest set bit, 32 when the word is zero
    function automatic logic [5:0] lowest_bit(input logic [31:0] v);
        logic [5:0] r;
        r = 6'd32;
        for (int i = BITS_PER_SET - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: sv/esw_ram.sv
// generic single-port-write, single-port-read ram with registered read
module esw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/esw_exec.sv
// execute logic: applies one action to the set entry read from memory
module esw_exec (
    input  esw_pkg::t_item   i_item,
    input  esw_pkg::t_entry  i_entry,
    output esw_pkg::t_entry  o_entry,
    output esw_pkg::t_ctl    o_ctl,
    output esw_pkg::t_result o_result
);
    import esw_pkg::*;

    logic [31:0] evbit;
    logic [5:0]  pend_low;
    logic [5:0]  wait_low;
    logic        ev_enabled;

    // lowest deliverable event and lowest waiting thread
    always_comb begin
        evbit      = 32'h1 << i_item.event_bit;
        pend_low   = lowest_bit(i_entry.pending & i_entry.enable);
        wait_low   = lowest_bit(i_entry.waiting);
        ev_enabled = (i_entry.enable & evbit) != 32'h0;
    end

    // action decode and entry update
    always_comb begin
        o_entry  = i_entry;
        o_ctl    = '0;
        o_result = '0;
        unique case (i_item.action)
            ACT_ALLOC: begin
                if (i_item.alloc_ok) begin
                    o_entry.enable        = ALL_ONES;
                    o_entry.pending       = 32'h0;
                    o_ctl.wr_en           = 1'b1;
                    o_ctl.use_set         = 1'b1;
                    o_result.result_value = i_item.set_addr;
                end else begin
                    o_result.status = ST_NO_FREE;
                end
            end
            ACT_FREE: begin
                if (!i_item.set_ok) begin
                    o_result.status = ST_INVALID;
                end else begin
                    o_ctl.use_clr = 1'b1;
                end
            end
            ACT_WAIT, ACT_RAISE, ACT_MASK, ACT_CLEAR: begin
                priority if (!i_item.set_ok) begin
                    o_result.status = ST_INVALID;
                end else if (!i_item.in_use) begin
                    o_result.status = ST_NOT_ALLOC;
                end else begin
                    o_ctl.wr_en = 1'b1;
                    unique case (i_item.action)
                        ACT_WAIT: begin
                            priority if (!i_item.thread_ok) begin
                                o_result.status = ST_INVALID;
                                o_ctl.wr_en     = 1'b0;
                            end else if (!pend_low[5]) begin
                                o_entry.pending = i_entry.pending
                                                  & ~(32'h1 << pend_low[4:0]);
                                o_result.result_value = {1'b0, pend_low[4:0]};
                            end else begin
                                o_entry.waiting = i_entry.waiting
                                                  | (32'h1 << i_item.thread_id);
                                o_result.status = ST_ENQUEUED;
                            end
                        end
                        ACT_RAISE: begin
                            if (!ev_enabled || wait_low[5]) begin
                                o_entry.pending = i_entry.pending | evbit;
                            end else begin
                                o_entry.waiting = i_entry.waiting
                                                  & ~(32'h1 << wait_low[4:0]);
                                o_result.wake_valid  = 1'b1;
                                o_result.wake_thread = wait_low[4:0];
                                o_result.wake_event  = i_item.event_bit;
                            end
                        end
                        ACT_MASK: begin
                            priority if (!i_item.mask_value) begin
                                o_entry.enable = i_entry.enable & ~evbit;
                            end else if (!ev_enabled) begin
                                o_entry.enable = i_entry.enable | evbit;
                                // unmask of a pending event hands it to a waiter
                                if (((i_entry.pending & evbit) != 32'h0) && !wait_low[5]) begin
                                    o_entry.waiting = i_entry.waiting
                                                      & ~(32'h1 << wait_low[4:0]);
                                    o_entry.pending = i_entry.pending & ~evbit;
                                    o_result.wake_valid  = 1'b1;
                                    o_result.wake_thread = wait_low[4:0];
                                    o_result.wake_event  = i_item.event_bit;
                                end
                            end else begin
                                o_ctl.wr_en = 1'b0;
                            end
                        end
                        default: begin
                            o_entry.pending = i_entry.pending & ~evbit;
                        end
                    endcase
                end
            end
            default: begin
                o_result.status = ST_INVALID;
            end
        endcase
    end

endmodule

// File: sv/event_set_wait_engine.sv
// top level of the event set wait engine: sequencer, allocation bitmap and set memory
//
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall    action, set_index, event_bit, mask_value,
//                                                 thread_id
// out       output     o_out_valid / i_out_stall  status, result_value, wake_valid,
//                                                 wake_thread, wake_event
//
// each item runs in two steps: the set memory read on accept, then execute and write-back
// the result lands in an output register, so a new item is taken while it waits
// when the result register is still held by a stall, execute waits in place
// reset clears the allocation bitmap and the per-set valid bits at once, no clearing pass
`include "event_set_wait_engine_assert.svh"

module event_set_wait_engine #(
    parameter int NUM_SETS    = 8,
    parameter int NUM_THREADS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_action,
    input  logic [5:0] i_set_index,
    input  logic [4:0] i_event_bit,
    input  logic       i_mask_value,
    input  logic [4:0] i_thread_id,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_status,
    output logic [5:0] o_result_value,
    output logic       o_wake_valid,
    output logic [4:0] o_wake_thread,
    output logic [4:0] o_wake_event
);
    import esw_pkg::*;

    localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state              r_state;
    logic [NUM_SETS-1:0] r_in_use;
    logic [NUM_SETS-1:0] r_valid;
    logic [SW-1:0]       r_addr;
    logic [2:0]          r_action;
    logic [4:0]          r_event_bit;
    logic                r_mask_value;
    logic [4:0]          r_thread_id;
    logic                r_set_ok;
    logic                r_thread_ok;
    logic                r_alloc_ok;
    logic                r_out_valid;
    t_result             r_result;

    logic       accept;
    logic       exec_go;
    logic [31:0] free_map;
    logic [5:0] free_low;
    logic [SW-1:0] n_addr;
    logic       n_set_ok;
    t_entry     rd_entry;
    t_entry     cur_entry;
    t_entry     new_entry;
    t_item      item;
    t_ctl       ctl;
    t_result    result;
    logic       out_wake;
    logic       out_no_free;

    // handshake and sequencing
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign exec_go    = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    // lowest free set and memory address for the incoming item
    always_comb begin
        free_map                 = '0;
        free_map[NUM_SETS-1:0]   = ~r_in_use;
        free_low = lowest_bit(free_map);
        n_set_ok = {1'b0, i_set_index} < 7'(NUM_SETS);
        n_addr   = (i_action == ACT_ALLOC) ? free_low[SW-1:0] : i_set_index[SW-1:0];
    end

    // set memory: enable, pending and waiting maps per set
    esw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SETS),
        .AW    (SW)
    ) u_set_ram (
        .i_clk     (i_clk),
        .i_wr_en   (exec_go && ctl.wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (new_entry),
        .i_rd_en   (accept),
        .i_rd_addr (n_addr),
        .o_rd_data (rd_entry)
    );

    // an entry never written reads as its reset value
    always_comb begin
        cur_entry = r_valid[r_addr] ? rd_entry : ENTRY_RESET;
        item = '{action:     r_action,
                 event_bit:  r_event_bit,
                 mask_value: r_mask_value,
                 thread_id:  r_thread_id,
                 set_addr:   6'(r_addr),
                 set_ok:     r_set_ok,
                 thread_ok:  r_thread_ok,
                 in_use:     r_in_use[r_addr],
                 alloc_ok:   r_alloc_ok};
    end

    esw_exec u_exec (
        .i_item   (item),
        .i_entry  (cur_entry),
        .o_entry  (new_entry),
        .o_ctl    (ctl),
        .o_result (result)
    );

    // state, bitmaps and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_use    <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register loads on execute, holds while stalled
            r_out_valid <= exec_go || (r_out_valid && i_out_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_addr       <= n_addr;
                        r_action     <= i_action;
                        r_event_bit  <= i_event_bit;
                        r_mask_value <= i_mask_value;
                        r_thread_id  <= i_thread_id;
                        r_set_ok     <= n_set_ok;
                        r_thread_ok  <= {1'b0, i_thread_id} < 6'(NUM_THREADS);
                        r_alloc_ok   <= !free_low[5];
                        r_state      <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_go) begin
                        r_result    <= result;
                        if (ctl.wr_en) begin
                            r_valid[r_addr] <= 1'b1;
                        end
                        if (ctl.use_set) begin
                            r_in_use[r_addr] <= 1'b1;
                        end
                        if (ctl.use_clr) begin
                            r_in_use[r_addr] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_result.status;
    assign o_result_value = r_result.result_value;
    assign o_wake_valid   = r_result.wake_valid;
    assign o_wake_thread  = r_result.wake_thread;
    assign o_wake_event   = r_result.wake_event;

    // checks
    assign out_wake    = r_out_valid && r_result.wake_valid;
    assign out_no_free = r_out_valid && (r_result.status == ST_NO_FREE);

    `ESW_ASSERT_NEXT(a_accept_enters_exec, i_clk, i_rst_n, accept, r_state == S_EXEC, "no exec")
    `ESW_ASSERT_SAME(a_wake_is_ok, i_clk, i_rst_n, out_wake, r_result.status == ST_OK, "bad wake")
    `ESW_ASSERT_SAME(a_no_free_full, i_clk, i_rst_n, out_no_free, &r_in_use, "set still free")

endmodule
